### sv/vefs_pkg.sv
// Shared types, constants and a helper function for the voxel exposed-face scan unit.
package vefs_pkg;

   // Grid geometry
   localparam int EDGE_CELLS  = 16;
   localparam int TOTAL_CELLS = EDGE_CELLS * EDGE_CELLS * EDGE_CELLS;
   localparam int COORD_W     = $clog2(EDGE_CELLS);
   localparam int IDX_W       = $clog2(TOTAL_CELLS);

   // Port field widths
   localparam int IN_IDX_W  = 12;
   localparam int OUT_IDX_W = 12;
   localparam int POS_W     = 4;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [COORD_W-1:0] coord_type;

   localparam coord_type COORD_MAX = COORD_W'(EDGE_CELLS - 1);
   localparam idx_type   STEP_X    = IDX_W'(1);
   localparam idx_type   STEP_Y    = IDX_W'(EDGE_CELLS);
   localparam idx_type   STEP_Z    = IDX_W'(EDGE_CELLS * EDGE_CELLS);
   localparam idx_type   LAST_IDX  = IDX_W'(TOTAL_CELLS - 1);

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_FETCH = 1'b1
   } kind_type;

   // Which cell of the neighborhood is being examined
   typedef enum logic [2:0] {
      SIDE_CENTER,
      SIDE_XP,
      SIDE_XN,
      SIDE_YP,
      SIDE_YN,
      SIDE_ZP,
      SIDE_ZN
   } side_type;

   typedef enum logic {
      ST_IDLE,
      ST_EVAL
   } state_type;

   // Cell under test: linear index plus its coordinates
   typedef struct packed {
      idx_type   idx;
      coord_type x;
      coord_type y;
      coord_type z;
   } cell_type;

   // Neighbor address unit result
   typedef struct packed {
      idx_type addr;
      logic    at_edge;
   } nbr_type;

   // Step order of the neighborhood walk
   function automatic side_type next_side(input side_type s);
      side_type n;
      unique case (s)
         SIDE_CENTER: n = SIDE_XP;
         SIDE_XP:     n = SIDE_XN;
         SIDE_XN:     n = SIDE_YP;
         SIDE_YP:     n = SIDE_YN;
         SIDE_YN:     n = SIDE_ZP;
         SIDE_ZP:     n = SIDE_ZN;
         default:     n = SIDE_CENTER;
      endcase
      return n;
   endfunction

endpackage

### sv/vefs_store.sv
// Voxel occupancy memory: one write port, one registered read port.
module vefs_store (
   input  logic              clock,
   input  logic              wr_en,
   input  vefs_pkg::idx_type wr_addr,
   input  logic              wr_data,
   input  vefs_pkg::idx_type rd_addr,
   output logic              rd_data
);

   logic mem [vefs_pkg::TOTAL_CELLS];
   logic rd_data_ff;

   // Write one cell
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read every cycle, data valid the next cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/vefs_nbr.sv
// Shared neighbor address unit: one add or subtract plus a grid-edge compare per step.
module vefs_nbr (
   input  vefs_pkg::cell_type cur_cell,
   input  vefs_pkg::side_type side,
   output vefs_pkg::nbr_type  nbr
);

   // Offset the cell index toward the chosen face and flag a face on the grid boundary
   always_comb begin
      unique case (side)
         vefs_pkg::SIDE_CENTER: begin
            nbr.addr    = cur_cell.idx;
            nbr.at_edge = 1'b0;
         end
         vefs_pkg::SIDE_XP: begin
            nbr.addr    = cur_cell.idx + vefs_pkg::STEP_X;
            nbr.at_edge = (cur_cell.x == vefs_pkg::COORD_MAX);
         end
         vefs_pkg::SIDE_XN: begin
            nbr.addr    = cur_cell.idx - vefs_pkg::STEP_X;
            nbr.at_edge = (cur_cell.x == '0);
         end
         vefs_pkg::SIDE_YP: begin
            nbr.addr    = cur_cell.idx + vefs_pkg::STEP_Y;
            nbr.at_edge = (cur_cell.y == vefs_pkg::COORD_MAX);
         end
         vefs_pkg::SIDE_YN: begin
            nbr.addr    = cur_cell.idx - vefs_pkg::STEP_Y;
            nbr.at_edge = (cur_cell.y == '0);
         end
         vefs_pkg::SIDE_ZP: begin
            nbr.addr    = cur_cell.idx + vefs_pkg::STEP_Z;
            nbr.at_edge = (cur_cell.z == vefs_pkg::COORD_MAX);
         end
         vefs_pkg::SIDE_ZN: begin
            nbr.addr    = cur_cell.idx - vefs_pkg::STEP_Z;
            nbr.at_edge = (cur_cell.z == '0);
         end
         default: begin
            nbr.addr    = cur_cell.idx;
            nbr.at_edge = 1'b0;
         end
      endcase
   end

endmodule

### sv/voxel_exposed_face_scan_unit.sv
// Top level: command sequencer walking the grid through one shared store read port.
// A write transfer completes in the cycle it is taken; busy stays low.
// A fetch examines cells from the cursor, one store read per cycle: the center alone
// for an empty cell, up to center plus six faces for a solid one. The result strobe
// is registered from the deciding read; a fetch at the grid end answers done in the
// next cycle. Reset clears cursor and sequencer, not the store; results never stall.
module voxel_exposed_face_scan_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_kind,
   input  logic [vefs_pkg::IN_IDX_W-1:0]  req_cell_index,
   input  logic                           req_solid,
   output logic                           rsp_strobe,
   output logic [vefs_pkg::OUT_IDX_W-1:0] rsp_exposed_index,
   output logic [vefs_pkg::POS_W-1:0]     rsp_pos_x,
   output logic [vefs_pkg::POS_W-1:0]     rsp_pos_y,
   output logic [vefs_pkg::POS_W-1:0]     rsp_pos_z,
   output logic                           rsp_done_res
);

   vefs_pkg::state_type state_ff, state_in;
   vefs_pkg::side_type  step_ff, step_in;
   vefs_pkg::cell_type  cell_ff, cell_in;
   logic                end_ff, end_in;
   logic                edge_ff, edge_in;

   logic                           rsp_strobe_ff, rsp_strobe_in;
   logic [vefs_pkg::OUT_IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [vefs_pkg::POS_W-1:0]     rsp_x_ff, rsp_x_in;
   logic [vefs_pkg::POS_W-1:0]     rsp_y_ff, rsp_y_in;
   logic [vefs_pkg::POS_W-1:0]     rsp_z_ff, rsp_z_in;
   logic                           rsp_done_ff, rsp_done_in;

   logic                accept;
   logic                write_go;
   logic                fetch_go;
   logic                wr_en;
   logic                rd_bit;
   logic                hit;
   logic                move_on;
   logic                last_cell;
   vefs_pkg::side_type  side_sel;
   vefs_pkg::nbr_type   nbr;
   vefs_pkg::cell_type  cell_next;

   assign busy     = (state_ff != vefs_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign write_go = accept && (vefs_pkg::kind_type'(req_kind) == vefs_pkg::KIND_WRITE);
   assign fetch_go = accept && (vefs_pkg::kind_type'(req_kind) == vefs_pkg::KIND_FETCH);
   assign wr_en    = write_go && (32'(req_cell_index) < vefs_pkg::TOTAL_CELLS);

   vefs_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (vefs_pkg::IDX_W'(req_cell_index)),
      .wr_data (req_solid),
      .rd_addr (nbr.addr),
      .rd_data (rd_bit)
   );

   vefs_nbr u_nbr (
      .cur_cell (cell_ff),
      .side     (side_sel),
      .nbr      (nbr)
   );

   // Decide on the read that just returned
   always_comb begin
      last_cell = (cell_ff.idx == vefs_pkg::LAST_IDX);
      hit       = 1'b0;
      move_on   = 1'b0;
      if (state_ff == vefs_pkg::ST_EVAL) begin
         if (step_ff == vefs_pkg::SIDE_CENTER) begin
            move_on = !rd_bit;
         end else begin
            hit     = edge_ff || !rd_bit;
            move_on = !hit && (step_ff == vefs_pkg::SIDE_ZN);
         end
      end
   end

   // Pick the next store read: the next cell's center is one step in +x
   always_comb begin
      if (state_ff == vefs_pkg::ST_IDLE) begin
         side_sel = vefs_pkg::SIDE_CENTER;
      end else if (move_on) begin
         side_sel = vefs_pkg::SIDE_XP;
      end else begin
         side_sel = vefs_pkg::next_side(step_ff);
      end
   end

   // Advance the cursor coordinates in index order
   always_comb begin
      cell_next     = cell_ff;
      cell_next.idx = cell_ff.idx + vefs_pkg::STEP_X;
      if (cell_ff.x == vefs_pkg::COORD_MAX) begin
         cell_next.x = '0;
         if (cell_ff.y == vefs_pkg::COORD_MAX) begin
            cell_next.y = '0;
            cell_next.z = cell_ff.z + vefs_pkg::COORD_W'(1);
         end else begin
            cell_next.y = cell_ff.y + vefs_pkg::COORD_W'(1);
         end
      end else begin
         cell_next.x = cell_ff.x + vefs_pkg::COORD_W'(1);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vefs_pkg::ST_IDLE: begin
            if (fetch_go && !end_ff) begin
               state_in = vefs_pkg::ST_EVAL;
            end
         end
         vefs_pkg::ST_EVAL: begin
            if (hit || (move_on && last_cell)) begin
               state_in = vefs_pkg::ST_IDLE;
            end
         end
         default: state_in = vefs_pkg::ST_IDLE;
      endcase
   end

   // Datapath and result updates
   always_comb begin
      step_in       = step_ff;
      cell_in       = cell_ff;
      end_in        = end_ff;
      edge_in       = nbr.at_edge;
      rsp_strobe_in = 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;
      rsp_done_in   = rsp_done_ff;
      unique case (state_ff)
         vefs_pkg::ST_IDLE: begin
            if (write_go) begin
               // rewind the cursor
               cell_in = '0;
               end_in  = 1'b0;
            end else if (fetch_go) begin
               if (end_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_index_in  = '0;
                  rsp_x_in      = '0;
                  rsp_y_in      = '0;
                  rsp_z_in      = '0;
                  rsp_done_in   = 1'b1;
               end else begin
                  step_in = vefs_pkg::SIDE_CENTER;
               end
            end
         end
         vefs_pkg::ST_EVAL: begin
            if (hit) begin
               // report the exposed cell and move past it
               rsp_strobe_in = 1'b1;
               rsp_index_in  = vefs_pkg::OUT_IDX_W'(cell_ff.idx);
               rsp_x_in      = vefs_pkg::POS_W'(cell_ff.x);
               rsp_y_in      = vefs_pkg::POS_W'(cell_ff.y);
               rsp_z_in      = vefs_pkg::POS_W'(cell_ff.z);
               rsp_done_in   = 1'b0;
               if (last_cell) begin
                  end_in = 1'b1;
               end else begin
                  cell_in = cell_next;
               end
            end else if (move_on) begin
               if (last_cell) begin
                  end_in        = 1'b1;
                  rsp_strobe_in = 1'b1;
                  rsp_index_in  = '0;
                  rsp_x_in      = '0;
                  rsp_y_in      = '0;
                  rsp_z_in      = '0;
                  rsp_done_in   = 1'b1;
               end else begin
                  cell_in = cell_next;
                  step_in = vefs_pkg::SIDE_CENTER;
               end
            end else begin
               step_in = vefs_pkg::next_side(step_ff);
            end
         end
         default: begin
            step_in = vefs_pkg::SIDE_CENTER;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= vefs_pkg::ST_IDLE;
         step_ff       <= vefs_pkg::SIDE_CENTER;
         cell_ff       <= '0;
         end_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         cell_ff       <= cell_in;
         end_ff        <= end_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      edge_ff      <= edge_in;
      rsp_index_ff <= rsp_index_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_z_ff     <= rsp_z_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_exposed_index = rsp_index_ff;
   assign rsp_pos_x         = rsp_x_ff;
   assign rsp_pos_y         = rsp_y_ff;
   assign rsp_pos_z         = rsp_z_ff;
   assign rsp_done_res      = rsp_done_ff;

endmodule

### bench/tb_voxel_exposed_face_scan_unit.sv
// Testbench for the voxel exposed-face scan unit: random-stall driver, scan predictor, checker.
`timescale 1ns / 1ps

module tb_voxel_exposed_face_scan_unit;

   localparam int RANDOM_ITEMS = 1950;
   // Worst case is every fetch walking the whole grid at seven reads per cell;
   // the real stimulus stays far below that, so this bound is several times over.
   localparam longint RUN_LIMIT_NS = 64'd40_000_000;

   // One expected fetch answer
   typedef struct packed {
      logic [vefs_pkg::OUT_IDX_W-1:0] index;
      logic [vefs_pkg::POS_W-1:0]     pos_x;
      logic [vefs_pkg::POS_W-1:0]     pos_y;
      logic [vefs_pkg::POS_W-1:0]     pos_z;
      logic                           done_flag;
   } exposed_cell_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic                           req_kind = 1'b0;
   logic [vefs_pkg::IN_IDX_W-1:0]  req_cell_index = '0;
   logic                           req_solid = 1'b0;
   logic                           rsp_strobe;
   logic [vefs_pkg::OUT_IDX_W-1:0] rsp_exposed_index;
   logic [vefs_pkg::POS_W-1:0]     rsp_pos_x;
   logic [vefs_pkg::POS_W-1:0]     rsp_pos_y;
   logic [vefs_pkg::POS_W-1:0]     rsp_pos_z;
   logic                           rsp_done_res;

   // Predictor copy of the grid and the scan cursor
   bit               voxel_grid [vefs_pkg::TOTAL_CELLS];
   int unsigned      scan_pos = 0;
   exposed_cell_type expected_hits [$];

   bit            start_held = 1'b0;
   bit            last_done = 1'b0;
   int unsigned   idle_pct = 0;
   int unsigned   items_sent = 0;
   int unsigned   writes_sent = 0;
   int unsigned   fetches_sent = 0;
   int unsigned   hits_checked = 0;
   int unsigned   done_checked = 0;
   int unsigned   error_count = 0;

   voxel_exposed_face_scan_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_cell_index    (req_cell_index),
      .req_solid         (req_solid),
      .rsp_strobe        (rsp_strobe),
      .rsp_exposed_index (rsp_exposed_index),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_pos_z         (rsp_pos_z),
      .rsp_done_res      (rsp_done_res)
   );

   always #2 clock = ~clock;

   // Treat anything outside the grid as empty
   function automatic bit solid_at(int x, int y, int z);
      if (x < 0 || y < 0 || z < 0 || x >= vefs_pkg::EDGE_CELLS || y >= vefs_pkg::EDGE_CELLS ||
          z >= vefs_pkg::EDGE_CELLS)
         return 1'b0;
      return voxel_grid[x + vefs_pkg::EDGE_CELLS * (y + vefs_pkg::EDGE_CELLS * z)];
   endfunction

   // Solid cell with at least one open face
   function automatic bit cell_exposed_now(int unsigned cell_id);
      int x, y, z;
      x = cell_id % vefs_pkg::EDGE_CELLS;
      y = (cell_id / vefs_pkg::EDGE_CELLS) % vefs_pkg::EDGE_CELLS;
      z = cell_id / (vefs_pkg::EDGE_CELLS * vefs_pkg::EDGE_CELLS);
      if (!voxel_grid[cell_id])
         return 1'b0;
      return !solid_at(x + 1, y, z) || !solid_at(x - 1, y, z) ||
             !solid_at(x, y + 1, z) || !solid_at(x, y - 1, z) ||
             !solid_at(x, y, z + 1) || !solid_at(x, y, z - 1);
   endfunction

   // Advance the cursor to the next exposed cell, or park it at the end
   function automatic exposed_cell_type predict_next_exposed();
      exposed_cell_type hit;
      int unsigned      cell_id;
      hit = '0;
      hit.done_flag = 1'b1;
      while (scan_pos < vefs_pkg::TOTAL_CELLS) begin
         cell_id = scan_pos;
         scan_pos++;
         if (cell_exposed_now(cell_id)) begin
            hit.index     = vefs_pkg::OUT_IDX_W'(cell_id);
            hit.pos_x     = vefs_pkg::POS_W'(cell_id % vefs_pkg::EDGE_CELLS);
            hit.pos_y     = vefs_pkg::POS_W'((cell_id / vefs_pkg::EDGE_CELLS) %
                                              vefs_pkg::EDGE_CELLS);
            hit.pos_z     = vefs_pkg::POS_W'(cell_id /
                                              (vefs_pkg::EDGE_CELLS * vefs_pkg::EDGE_CELLS));
            hit.done_flag = 1'b0;
            return hit;
         end
      end
      return hit;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40)
         $display("ERROR %0t ns: %s", $time, msg);
   endtask

   // Drive one transfer, hold it until taken, then update the predictor
   task automatic send_transfer(input vefs_pkg::kind_type kind, input int unsigned cell_id,
                                input bit solid);
      exposed_cell_type hit;
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         if (start_held) begin
            start      <= 1'b0;
            start_held  = 1'b0;
         end
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      start          <= 1'b1;
      start_held      = 1'b1;
      req_kind       <= kind;
      req_cell_index <= vefs_pkg::IN_IDX_W'(cell_id);
      req_solid      <= solid;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (kind == vefs_pkg::KIND_WRITE) begin
         voxel_grid[cell_id] = solid;
         scan_pos            = 0;
         writes_sent++;
      end else begin
         hit       = predict_next_exposed();
         last_done = hit.done_flag;
         expected_hits.push_back(hit);
         fetches_sent++;
      end
   endtask

   // Fetch with random don't-care fields
   task automatic send_fetch();
      send_transfer(vefs_pkg::KIND_FETCH, $urandom_range(0, vefs_pkg::TOTAL_CELLS - 1),
                    $urandom_range(0, 1));
   endtask

   // Drop start and hold off until every fetch has answered
   task automatic pause_until_drained();
      if (start_held) begin
         start      <= 1'b0;
         start_held  = 1'b0;
      end
      do @(posedge clock); while (expected_hits.size() != 0);
   endtask

   // Compare each result strobe with the oldest pending fetch
   always @(posedge clock) begin : check_results
      exposed_cell_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_hits.size() == 0) begin
            report_mismatch($sformatf("result with no fetch pending: index %0d done %0b",
                                      rsp_exposed_index, rsp_done_res));
         end else begin
            want = expected_hits.pop_front();
            if (rsp_exposed_index !== want.index)
               report_mismatch($sformatf("exposed_index got %0d want %0d",
                                         rsp_exposed_index, want.index));
            if (rsp_pos_x !== want.pos_x)
               report_mismatch($sformatf("pos_x got %0d want %0d (cell %0d)",
                                         rsp_pos_x, want.pos_x, want.index));
            if (rsp_pos_y !== want.pos_y)
               report_mismatch($sformatf("pos_y got %0d want %0d (cell %0d)",
                                         rsp_pos_y, want.pos_y, want.index));
            if (rsp_pos_z !== want.pos_z)
               report_mismatch($sformatf("pos_z got %0d want %0d (cell %0d)",
                                         rsp_pos_z, want.pos_z, want.index));
            if (rsp_done_res !== want.done_flag)
               report_mismatch($sformatf("done_res got %0b want %0b (cell %0d)",
                                         rsp_done_res, want.done_flag, want.index));
            if (want.done_flag)
               done_checked++;
            else
               hits_checked++;
         end
      end
   end

   // Write every cell empty so no scan ever reads an unwritten cell
   task automatic test_clear_grid();
      for (int unsigned c = 0; c < vefs_pkg::TOTAL_CELLS; c++)
         send_transfer(vefs_pkg::KIND_WRITE, c, 1'b0);
   endtask

   // Empty grid, corner cells, repeated done, and an enclosed cell skipped
   // A 12-bit index cannot leave the 16^3 grid, so the ignored-write case has no stimulus.
   task automatic test_directed_scan();
      int unsigned center;
      center = 5 + vefs_pkg::EDGE_CELLS * (5 + vefs_pkg::EDGE_CELLS * 5);
      // walk off the end of an empty grid, then answer done at once
      send_fetch();
      send_fetch();
      // first corner: write rewinds, one hit, then done
      send_transfer(vefs_pkg::KIND_WRITE, 0, 1'b1);
      send_fetch();
      send_fetch();
      // far corner gives the largest index and coordinates
      send_transfer(vefs_pkg::KIND_WRITE, vefs_pkg::TOTAL_CELLS - 1, 1'b1);
      send_fetch();
      send_fetch();
      send_fetch();
      send_transfer(vefs_pkg::KIND_WRITE, 0, 1'b0);
      send_transfer(vefs_pkg::KIND_WRITE, vefs_pkg::TOTAL_CELLS - 1, 1'b0);
      // plus shape: arms are exposed, the center is closed on all six faces
      send_transfer(vefs_pkg::KIND_WRITE, center, 1'b1);
      send_transfer(vefs_pkg::KIND_WRITE, center + 1, 1'b1);
      send_transfer(vefs_pkg::KIND_WRITE, center - 1, 1'b1);
      send_transfer(vefs_pkg::KIND_WRITE, center + vefs_pkg::EDGE_CELLS, 1'b1);
      send_transfer(vefs_pkg::KIND_WRITE, center - vefs_pkg::EDGE_CELLS, 1'b1);
      send_transfer(vefs_pkg::KIND_WRITE,
                    center + vefs_pkg::EDGE_CELLS * vefs_pkg::EDGE_CELLS, 1'b1);
      send_transfer(vefs_pkg::KIND_WRITE,
                    center - vefs_pkg::EDGE_CELLS * vefs_pkg::EDGE_CELLS, 1'b1);
      repeat (7) send_fetch();
      pause_until_drained();
   endtask

   // Build random solid boxes, walk them to done with random rewinds, erase them
   task automatic test_random_boxes();
      int unsigned base, sx, sy, sz, x0, y0, z0, fill_pct, idx, fetched;
      int unsigned box_cells [$];
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         // no idling in the last quarter
         if (items_sent - base > RANDOM_ITEMS * 3 / 4)
            idle_pct = 0;
         else
            case ($urandom_range(0, 2))
               0:       idle_pct = 0;
               1:       idle_pct = 15;
               default: idle_pct = 50;
            endcase
         case ($urandom_range(0, 2))
            0:       fill_pct = 60;
            1:       fill_pct = 85;
            default: fill_pct = 100;
         endcase
         box_cells.delete();
         sx = $urandom_range(1, 4);
         sy = $urandom_range(1, 4);
         sz = $urandom_range(1, 4);
         x0 = $urandom_range(0, vefs_pkg::EDGE_CELLS - sx);
         y0 = $urandom_range(0, vefs_pkg::EDGE_CELLS - sy);
         z0 = $urandom_range(0, vefs_pkg::EDGE_CELLS - sz);
         // fill the box, with stray writes elsewhere now and then
         for (int unsigned z = z0; z < z0 + sz; z++)
            for (int unsigned y = y0; y < y0 + sy; y++)
               for (int unsigned x = x0; x < x0 + sx; x++) begin
                  idx = x + vefs_pkg::EDGE_CELLS * (y + vefs_pkg::EDGE_CELLS * z);
                  if ($urandom_range(1, 100) <= fill_pct) begin
                     send_transfer(vefs_pkg::KIND_WRITE, idx, 1'b1);
                     box_cells.push_back(idx);
                  end else if ($urandom_range(0, 3) == 0) begin
                     idx = $urandom_range(0, vefs_pkg::TOTAL_CELLS - 1);
                     send_transfer(vefs_pkg::KIND_WRITE, idx, $urandom_range(0, 4) == 0);
                     box_cells.push_back(idx);
                  end
               end
         // walk to done; a write in the middle rewinds the cursor
         fetched = 0;
         do begin
            send_fetch();
            fetched++;
            if ($urandom_range(0, 15) == 0) begin
               if (box_cells.size() != 0)
                  idx = box_cells[$urandom_range(0, box_cells.size() - 1)];
               else
                  idx = $urandom_range(0, vefs_pkg::TOTAL_CELLS - 1);
               send_transfer(vefs_pkg::KIND_WRITE, idx, $urandom_range(0, 1));
               box_cells.push_back(idx);
            end
         end while (!last_done && fetched < 150);
         if (last_done && $urandom_range(0, 1) == 1)
            send_fetch();
         if ($urandom_range(0, 2) == 0)
            pause_until_drained();
         // erase what was written so the next box starts on a clean grid
         foreach (box_cells[i])
            send_transfer(vefs_pkg::KIND_WRITE, box_cells[i], 1'b0);
      end
   endtask

   initial begin : run_tests
      int unsigned drain_wait;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 20;
      test_clear_grid();
      idle_pct = 30;
      test_directed_scan();
      test_random_boxes();
      // drain the last fetches, then watch for stray strobes
      if (start_held) begin
         start      <= 1'b0;
         start_held  = 1'b0;
      end
      drain_wait = 0;
      do begin
         @(posedge clock);
         drain_wait++;
      end while (expected_hits.size() != 0 && drain_wait < 100000);
      if (expected_hits.size() != 0)
         report_mismatch($sformatf("%0d fetch results never arrived", expected_hits.size()));
      repeat (20) @(posedge clock);
      $display("Sent %0d writes and %0d fetches; checked %0d exposed cells and %0d done answers.",
               writes_sent, fetches_sent, hits_checked, done_checked);
      $display("Scans covered an emptied grid, corner cells, a closed plus shape and random boxes.");
      if (error_count == 0) begin
         $display("PASS voxel_exposed_face_scan_unit");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAIL voxel_exposed_face_scan_unit");
      end
      $finish;
   end

   // Stop a hung run
   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("timeout: scan unit stopped answering, %0d results pending", expected_hits.size());
      $display("FAIL voxel_exposed_face_scan_unit");
      $finish;
   end

endmodule

### filelist.f
sv/vefs_pkg.sv
sv/vefs_store.sv
sv/vefs_nbr.sv
sv/voxel_exposed_face_scan_unit.sv
bench/tb_voxel_exposed_face_scan_unit.sv
